// ===== hdl/postfix_expression_evaluator_defines.svh =====
// Assertion macros shared by the postfix expression evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, checked on clk, off during rst.
`define PEE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define PEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pee_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
package pee_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCHAR = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;
  localparam logic [2:0] ST_NOTONE  = 3'd5;

  localparam int RESULT_W = 32;

  // Arithmetic unit operations
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t OP_ADD = 2'd0;
  localparam alu_op_t OP_SUB = 2'd1;
  localparam alu_op_t OP_MUL = 2'd2;
  localparam alu_op_t OP_DIV = 2'd3;

  // Request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

endpackage

// ===== hdl/postfix_expression_evaluator.sv =====
// Top level of the postfix expression evaluator: sequencer, stack and result register.
// '*' and '/' use the bit-serial multiply/divide in the shared arithmetic unit, while
// '+' and '-' need no iteration there. The end byte's result sits in an output register.
// One item in flight at a time.
// Reset clears the stack count, the error and the output valid; stack data is not reset.
`include "postfix_expression_evaluator_defines.svh"
module postfix_expression_evaluator import pee_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                symbol_valid,
  output logic                symbol_stall,
  input  logic [7:0]          symbol,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [RESULT_W-1:0] result_value,
  output logic [2:0]          status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [7:0]            sym;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [2:0]            err;
  logic [2:0]            err_next;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         addr_top;
  logic [AW-1:0]         addr_nos;
  logic [DATA_WIDTH-1:0] rd_top;
  logic [DATA_WIDTH-1:0] rd_nos;

  alu_ctl_t              alu_ctl;
  alu_op_t               sym_op;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_result;

  logic                  is_digit;
  logic                  is_op;
  logic                  out_load;
  logic [2:0]            out_status;
  logic [RESULT_W-1:0]   out_value;
  logic                  accept;

  assign accept       = symbol_valid && !symbol_stall;
  assign symbol_stall = (state != S_IDLE);

  // Stack reads follow the current depth every cycle
  assign addr_top = AW'(count - CW'(1));
  assign addr_nos = AW'(count - CW'(2));

  pee_stack #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_stack (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (addr_top),
    .rd_addr_b (addr_nos),
    .rd_data_a (rd_top),
    .rd_data_b (rd_nos)
  );

  pee_alu #(
    .W (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .lhs    (rd_nos),
    .rhs    (rd_top),
    .done   (alu_done),
    .result (alu_result)
  );

  // Symbol decode
  assign is_digit = (sym >= CH_0) && (sym <= CH_9);
  assign is_op    = (sym == CH_PLUS) || (sym == CH_MINUS) ||
                    (sym == CH_STAR) || (sym == CH_SLASH);

  always_comb begin
    unique case (sym)
      CH_MINUS: sym_op = OP_SUB;
      CH_STAR:  sym_op = OP_MUL;
      CH_SLASH: sym_op = OP_DIV;
      default:  sym_op = OP_ADD;
    endcase
  end

  // Final status and value for an end byte
  assign out_status = (err != ST_OK) ? err :
                      ((count == CW'(1)) ? ST_OK : ST_NOTONE);
  assign out_value  = (out_status == ST_OK) ? RESULT_W'(rd_top) : '0;

  // Sequencer
  always_comb begin
    state_next  = state;
    count_next  = count;
    err_next    = err;
    wr_en       = 1'b0;
    wr_addr     = addr_nos;
    wr_data     = alu_result;
    alu_ctl     = '{start: 1'b0, op: sym_op};
    out_load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        if (sym == CH_NUL) begin
          if (!result_valid || !result_stall) begin
            out_load   = 1'b1;
            count_next = '0;
            err_next   = ST_OK;
          end else begin
            state_next = S_EXEC;
          end
        end else if (err != ST_OK) begin
          // sticky error: drop the byte
          state_next = S_IDLE;
        end else if (is_digit) begin
          if (count >= CW'(STACK_DEPTH)) begin
            err_next = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = AW'(count);
            wr_data    = DATA_WIDTH'(sym[3:0]);
            count_next = count + CW'(1);
          end
        end else if (is_op) begin
          if (count < CW'(2)) begin
            err_next = ST_UNDER;
          end else if (sym == CH_SLASH && rd_top == '0) begin
            err_next = ST_DIVZERO;
          end else begin
            alu_ctl.start = 1'b1;
            state_next    = S_WAIT;
          end
        end else begin
          err_next = ST_BADCHAR;
        end
      end
      S_WAIT: begin
        // replace the two operands with the result
        if (alu_done) begin
          wr_en      = 1'b1;
          count_next = count - CW'(1);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      err   <= ST_OK;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
    end
  end

  // Captured symbol
  always_ff @(posedge clk) begin
    if (accept) begin
      sym <= symbol;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= out_value;
      status       <= out_status;
    end
  end

  // Checks
  `PEE_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(STACK_DEPTH), "stack count overflow")
  `PEE_ASSERT_NOW(a_err_value_zero, result_valid && status != ST_OK,
                  result_value == '0, "nonzero value with error")
  `PEE_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC, "accepted item not executed")
  `PEE_ASSERT_NOW(a_done_in_wait, alu_done, state == S_WAIT, "arithmetic result outside wait")

endmodule

// ===== hdl/pee_stack.sv =====
// Operand stack memory: one write port, two registered read ports.
module pee_stack #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== hdl/pee_alu.sv =====
// Shared arithmetic unit: one adder serves add, subtract, shift-add
// multiply and restoring divide, one bit per cycle for multiply and divide.
module pee_alu import pee_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  alu_ctl_t     ctl,
  input  logic [W-1:0] lhs,
  input  logic [W-1:0] rhs,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int NW = $clog2(W + 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_RUN  = 2'd1;
  localparam logic [1:0] P_FIN  = 2'd2;

  logic [1:0]    phase;
  alu_op_t       op;
  logic [W-1:0]  acc;
  logic [W-1:0]  opa;
  logic [W-1:0]  opb;
  logic [NW-1:0] cnt;
  logic          neg;

  logic [W:0]    add_x;
  logic [W:0]    add_y;
  logic          add_sub;
  logic [W:0]    add_sum;
  logic [W-1:0]  lhs_mag;
  logic [W-1:0]  rhs_mag;

  assign lhs_mag = lhs[W-1] ? (~lhs + W'(1)) : lhs;
  assign rhs_mag = rhs[W-1] ? (~rhs + W'(1)) : rhs;

  // Operand selection for the single adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (phase)
      P_IDLE: begin
        add_x   = {1'b0, lhs};
        add_y   = {1'b0, rhs};
        add_sub = (ctl.op == OP_SUB);
      end
      P_RUN: begin
        if (op == OP_MUL) begin
          add_x = {1'b0, acc};
          add_y = {1'b0, opa};
        end else begin
          // trial subtract of divisor from shifted remainder
          add_x   = {acc, opa[W-1]};
          add_y   = {1'b0, opb};
          add_sub = 1'b1;
        end
      end
      P_FIN: begin
        // negate the quotient magnitude
        add_y   = {1'b0, opa};
        add_sub = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + (W+1)'(add_sub);

  // Sequencing of the iterative operations
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (ctl.start) begin
            op <= ctl.op;
            if (ctl.op == OP_ADD || ctl.op == OP_SUB) begin
              result <= add_sum[W-1:0];
              done   <= 1'b1;
            end else if (ctl.op == OP_MUL) begin
              acc   <= '0;
              opa   <= lhs;
              opb   <= rhs;
              cnt   <= NW'(W);
              phase <= P_RUN;
            end else begin
              acc   <= '0;
              opa   <= lhs_mag;
              opb   <= rhs_mag;
              neg   <= lhs[W-1] ^ rhs[W-1];
              cnt   <= NW'(W);
              phase <= P_RUN;
            end
          end
        end
        P_RUN: begin
          if (op == OP_MUL) begin
            if (opb[0]) begin
              acc <= add_sum[W-1:0];
            end
            opa <= {opa[W-2:0], 1'b0};
            opb <= {1'b0, opb[W-1:1]};
          end else if (!add_sum[W]) begin
            acc <= add_sum[W-1:0];
            opa <= {opa[W-2:0], 1'b1};
          end else begin
            acc <= add_x[W-1:0];
            opa <= {opa[W-2:0], 1'b0};
          end
          cnt <= cnt - NW'(1);
          if (cnt == NW'(1)) begin
            phase <= P_FIN;
          end
        end
        P_FIN: begin
          if (op == OP_MUL) begin
            result <= acc;
          end else begin
            result <= neg ? add_sum[W-1:0] : opa;
          end
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/pee_result_checker.sv =====
`timescale 1ns / 1ps
// Checker for the postfix evaluator: tracks the operand stack and compares every result item.
module pee_result_checker import pee_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                symbol_valid,
  input  logic                symbol_stall,
  input  logic [7:0]          symbol,
  input  logic                result_valid,
  input  logic                result_stall,
  input  logic [RESULT_W-1:0] result_value,
  input  logic [2:0]          status,
  output int                  mismatches,
  output int                  answers_waiting
);

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [RESULT_W-1:0] value;
    logic [2:0]          code;
  } answer_t;

  // Shadow copy of the evaluator state
  logic [31:0] operands [DEPTH];
  int          opnd_count = 0;
  logic [2:0]  fault = ST_OK;
  answer_t     answers [$];
  int          bad = 0;

  // Signed quotient truncated toward zero; MIN / -1 wraps back to MIN
  function automatic logic [31:0] quotient(logic [31:0] lhs, logic [31:0] rhs);
    logic [31:0] mag_l, mag_r, q;
    mag_l = lhs[31] ? -lhs : lhs;
    mag_r = rhs[31] ? -rhs : rhs;
    q = mag_l / mag_r;
    if (lhs[31] != rhs[31]) q = -q;
    return q;
  endfunction

  // Apply one expression byte to the shadow stack; the end byte yields an answer
  task automatic eval_symbol(input logic [7:0] sym);
    logic [31:0] lhs, rhs, res;
    answer_t ans;
    if (sym == CH_NUL) begin
      ans.code = fault;
      ans.value = '0;
      if (fault == ST_OK) begin
        if (opnd_count == 1) ans.value = operands[0];
        else ans.code = ST_NOTONE;
      end
      answers.push_back(ans);
      opnd_count = 0;
      fault = ST_OK;
    end else if (fault == ST_OK) begin
      // after the first error everything up to the end byte is dropped
      if (sym >= CH_0 && sym <= CH_9) begin
        if (opnd_count >= DEPTH) begin
          fault = ST_FULL;
        end else begin
          operands[opnd_count] = 32'(sym - CH_0);
          opnd_count++;
        end
      end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH) begin
        if (opnd_count < 2) begin
          fault = ST_UNDER;
        end else begin
          rhs = operands[opnd_count - 1];
          lhs = operands[opnd_count - 2];
          case (sym)
            CH_PLUS:  res = lhs + rhs;
            CH_MINUS: res = lhs - rhs;
            CH_STAR:  res = lhs * rhs;
            default:  res = (rhs == '0) ? '0 : quotient(lhs, rhs);
          endcase
          if (sym == CH_SLASH && rhs == '0) begin
            fault = ST_DIVZERO;
          end else begin
            opnd_count--;
            operands[opnd_count - 1] = res;
          end
        end
      end else begin
        fault = ST_BADCHAR;
      end
    end
  endtask

  // Compare outgoing items first, then predict from the incoming one
  always @(posedge clk) begin : watch
    answer_t want;
    if (rst) begin
      opnd_count = 0;
      fault = ST_OK;
      answers.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (answers.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("mismatch: result with nothing pending, value %0d status %0d",
                     $signed(result_value), status);
        end else begin
          want = answers.pop_front();
          if (result_value !== want.value || status !== want.code) begin
            bad++;
            if (bad <= 10)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       $signed(want.value), want.code, $signed(result_value), status);
          end
        end
      end
      if (symbol_valid && !symbol_stall) eval_symbol(symbol);
    end
    mismatches <= bad;
    answers_waiting <= answers.size();
  end

endmodule

// ===== sim/tb_postfix_expression_evaluator.sv =====
`timescale 1ns / 1ps
// Testbench top for the postfix evaluator: clock, reset, expression stimulus and verdict.
module tb_postfix_expression_evaluator;
  import pee_pkg::*;

  localparam int ITEM_TARGET   = 1550;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int STACK_SLOTS   = 16;

  logic                clk;
  logic                rst;
  logic                symbol_valid;
  logic                symbol_stall;
  logic [7:0]          symbol;
  logic                result_valid;
  logic                result_stall;
  logic [RESULT_W-1:0] result_value;
  logic [2:0]          status;

  int         mismatches;
  int         answers_waiting;
  logic       symbol_taken;
  int         idle_cycles = 0;
  int         stall_left = 0;
  int         items_sent = 0;
  bit         burst;
  logic [7:0] expr_q [$];

  postfix_expression_evaluator dut (
    .clk          (clk),
    .rst          (rst),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall),
    .symbol       (symbol),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_value (result_value),
    .status       (status)
  );

  pee_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .symbol_valid    (symbol_valid),
    .symbol_stall    (symbol_stall),
    .symbol          (symbol),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_value    (result_value),
    .status          (status),
    .mismatches      (mismatches),
    .answers_waiting (answers_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Input acceptance as seen at the last rising edge
  always_ff @(posedge clk) symbol_taken <= symbol_valid && !symbol_stall;

  // Watchdog: too long without any accepted item on either side
  always @(posedge clk) begin
    if (rst || (symbol_valid && !symbol_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result back-pressure: open stretches, short stalls, occasional long ones
  always @(negedge clk) begin : stall_gen
    int pick;
    if (stall_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        result_stall <= 1'b0;
        stall_left = $urandom_range(1, 30);
      end else if (pick < 88) begin
        result_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (pick < 97) begin
        result_stall <= 1'b1;
        stall_left = $urandom_range(4, 12);
      end else begin
        result_stall <= 1'b1;
        stall_left = $urandom_range(20, 60);
      end
    end else begin
      stall_left = stall_left - 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op(int star_pct);
    if ($urandom_range(0, 99) < star_pct) return CH_STAR;
    case ($urandom_range(0, 2))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      default: return CH_SLASH;
    endcase
  endfunction

  // Drive one item and hold it until accepted; entered and left at a falling edge
  task automatic send_symbol(input logic [7:0] sym, input int gap);
    if (gap > 0) begin
      symbol_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    symbol_valid <= 1'b1;
    symbol <= sym;
    do @(negedge clk); while (!symbol_taken);
  endtask

  task automatic send_expr(input bit counted);
    foreach (expr_q[i]) send_symbol(expr_q[i], burst ? 0 : pick_gap());
    if (counted) items_sent += expr_q.size();
    expr_q.delete();
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) expr_q.push_back(t[i]);
  endtask

  // Sender holds off until every pending result has come out
  task automatic settle_answers();
    symbol_valid <= 1'b0;
    do @(negedge clk); while (answers_waiting != 0);
  endtask

  // Random well-formed expression; optionally left with more than one operand
  task automatic build_chain(input int star_pct, input bit reduce);
    int depth, len;
    depth = 0;
    len = $urandom_range(1, 30);
    repeat (len) begin
      if (depth < 2 || (depth < STACK_SLOTS && $urandom_range(0, 1) == 1)) begin
        expr_q.push_back(rand_digit());
        depth++;
      end else begin
        expr_q.push_back(rand_op(star_pct));
        depth--;
      end
    end
    if (reduce) begin
      while (depth > 1) begin
        expr_q.push_back(rand_op(star_pct));
        depth--;
      end
    end
    expr_q.push_back(CH_NUL);
  endtask

  initial begin : stimulus
    int mode;
    rst = 1'b1;
    symbol_valid = 1'b0;
    symbol = CH_NUL;
    result_stall = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every operator, bad byte with sticky tail, underflow,
    // divide by zero, leftover operands and an empty expression
    add_text("93-27*+4/");
    expr_q.push_back(CH_NUL);
    expr_q.push_back(8'hFF);
    add_text("5");
    expr_q.push_back(CH_NUL);
    add_text("+");
    expr_q.push_back(CH_NUL);
    add_text("50/");
    expr_q.push_back(CH_NUL);
    add_text("12");
    expr_q.push_back(CH_NUL);
    expr_q.push_back(CH_NUL);
    burst = 1'b0;
    send_expr(1'b1);
    settle_answers();

    // Random expressions, mostly well formed
    while (items_sent < ITEM_TARGET) begin
      burst = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
        build_chain(20, $urandom_range(0, 9) != 0);
      end else if (mode < 67) begin
        // product-heavy so values wrap
        build_chain(70, 1'b1);
      end else if (mode < 77) begin
        // broken: stray byte somewhere, or an operator with nothing to pop
        build_chain(25, 1'b1);
        if ($urandom_range(0, 1) == 1)
          expr_q.insert($urandom_range(0, expr_q.size() - 1), 8'($urandom_range(1, 255)));
        else
          expr_q.push_front(rand_op(25));
      end else if (mode < 84) begin
        // fill the stack, then either overflow it or fold it back down
        repeat (STACK_SLOTS) expr_q.push_back(rand_digit());
        if ($urandom_range(0, 1) == 1) begin
          expr_q.push_back(rand_digit());
          repeat ($urandom_range(0, 5))
            expr_q.push_back(($urandom_range(0, 1) == 1) ? rand_digit() : rand_op(25));
        end else begin
          repeat (STACK_SLOTS - 1) expr_q.push_back(rand_op(40));
        end
        expr_q.push_back(CH_NUL);
      end else if (mode < 90) begin
        // 2^31 wraps to the most negative value, then divide by -1 or 1
        add_text("88*88**88*88***88*2**");
        if ($urandom_range(0, 1) == 1) add_text("01-");
        else add_text("1");
        expr_q.push_back(CH_SLASH);
        expr_q.push_back(CH_NUL);
      end else begin
        // raw noise bytes
        repeat ($urandom_range(1, 6)) expr_q.push_back(8'($urandom_range(0, 255)));
        expr_q.push_back(CH_NUL);
      end
      send_expr(mode < 90);
      if ($urandom_range(0, 29) == 0) settle_answers();
    end

    settle_answers();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && answers_waiting == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
